// ===== sv/cel_pkg.sv =====
// ----------------------------------------------------------------------------
// cel_pkg
// shared types, field widths and helpers of the circular event log
// ----------------------------------------------------------------------------
package cel_pkg;

  localparam int unsigned DEF_MAX_SLOTS    = 64;
  localparam int unsigned DEF_PAYLOAD_BITS = 32;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_RESET = 64;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TYPE_W    = 8;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned LIMIT_W   = 10;
  localparam int unsigned COUNT_W   = 10;

  localparam int unsigned IN_TYPE_LSB    = TIME_W;
  localparam int unsigned IN_PAYLOAD_LSB = TIME_W + TYPE_W;
  localparam int unsigned IN_LIMIT_LSB   = TIME_W + TYPE_W + PAYLOAD_W;
  localparam int unsigned IN_FIELDS_W    = IN_LIMIT_LSB + LIMIT_W;
  localparam int unsigned IN_DATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned OUT_FIELDS_W = TIME_W + TYPE_W + PAYLOAD_W + COUNT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND       = 2'd0,
    OP_START_NEWEST = 2'd1,
    OP_START_UNREP  = 2'd2,
    OP_NEXT         = 2'd3
  } op_e;

  typedef struct packed {
    logic               entry_valid;
    logic               from_store;
    logic [COUNT_W-1:0] stored_count;
  } res_meta_t;

  // slot count in effect: clamp to 2..max
  function automatic logic [CFG_W-1:0] clamp_slots(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] max);
    logic [CFG_W-1:0] r;
    r = v;
    if (r < CFG_W'(2)) r = CFG_W'(2);
    if (r > max) r = max;
    return r;
  endfunction

endpackage

// ===== sv/cel_store.sv =====
// ----------------------------------------------------------------------------
// cel_store
// entry memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module cel_store import cel_pkg::*; #(
  parameter int unsigned MAX_SLOTS    = DEF_MAX_SLOTS,
  parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS,
  localparam int unsigned IDX_W       = $clog2(MAX_SLOTS)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IDX_W-1:0]        waddr_i,
  input  logic [TIME_W-1:0]       wtime_i,
  input  logic [TYPE_W-1:0]       wtype_i,
  input  logic [PAYLOAD_BITS-1:0] wpayload_i,
  input  logic                    re_i,
  input  logic [IDX_W-1:0]        raddr_i,
  output logic [TIME_W-1:0]       rtime_o,
  output logic [TYPE_W-1:0]       rtype_o,
  output logic [PAYLOAD_BITS-1:0] rpayload_o
);

  logic [TIME_W-1:0]       time_mem    [MAX_SLOTS];
  logic [TYPE_W-1:0]       type_mem    [MAX_SLOTS];
  logic [PAYLOAD_BITS-1:0] payload_mem [MAX_SLOTS];

  logic [TIME_W-1:0]       rtime_q;
  logic [TYPE_W-1:0]       rtype_q;
  logic [PAYLOAD_BITS-1:0] rpayload_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[waddr_i]    <= wtime_i;
      type_mem[waddr_i]    <= wtype_i;
      payload_mem[waddr_i] <= wpayload_i;
    end
    if (re_i) begin
      rtime_q    <= time_mem[raddr_i];
      rtype_q    <= type_mem[raddr_i];
      rpayload_q <= payload_mem[raddr_i];
    end
  end

  assign rtime_o    = rtime_q;
  assign rtype_o    = rtype_q;
  assign rpayload_o = rpayload_q;

endmodule

// ===== sv/cel_ctrl.sv =====
// ----------------------------------------------------------------------------
// cel_ctrl
// ring pointers, fill count and read cursor of the event log
// ----------------------------------------------------------------------------
module cel_ctrl import cel_pkg::*; #(
  parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS,
  localparam int unsigned IDX_W    = $clog2(MAX_SLOTS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               fire_i,
  input  op_e                op_i,
  input  logic [LIMIT_W-1:0] read_limit_i,
  output logic               mem_we_o,
  output logic [IDX_W-1:0]   mem_waddr_o,
  output logic [IDX_W-1:0]   mem_raddr_o,
  output res_meta_t          meta_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned XW    = IDX_W + 1;
  localparam logic [CNT_W-1:0] S_RESET =
    CNT_W'(clamp_slots(CFG_W'(CFG_RESET), CFG_W'(MAX_SLOTS)));

  logic [CNT_W-1:0] s_q, s_d, s_new;
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d, lr_q, lr_d;
  logic [IDX_W-1:0] cur_q, cur_d, goal_q, goal_d, done_q, done_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic             open_q, open_d, unrep_q, unrep_d;

  logic             full, can_read, lim_all;
  logic [IDX_W-1:0] s_last, unrep_goal, stored_chk;

  function automatic logic [IDX_W-1:0] inc_slot(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] s);
    logic [XW-1:0] nx;
    nx = XW'(i) + XW'(1);
    return (nx >= XW'(s)) ? '0 : IDX_W'(nx);
  endfunction

  function automatic logic [IDX_W-1:0] dec_slot(input logic [IDX_W-1:0] i,
                                                input logic [CNT_W-1:0] s);
    return (i == '0) ? IDX_W'(s - CNT_W'(1)) : i - IDX_W'(1);
  endfunction

  assign s_new    = CNT_W'(clamp_slots(cfg_wdata_i, CFG_W'(MAX_SLOTS)));
  assign s_last   = IDX_W'(s_q - CNT_W'(1));
  assign full     = (count_q == s_last);
  assign can_read = open_q && (done_q < goal_q);
  assign lim_all  = (read_limit_i == '0) || (read_limit_i > LIMIT_W'(count_q));

  always_comb begin
    if (head_q > lr_q) begin
      unrep_goal = head_q - lr_q - IDX_W'(1);
    end else begin
      unrep_goal = IDX_W'(XW'(s_q) - XW'(lr_q - head_q) - XW'(1));
    end
  end

  always_comb begin
    s_d      = s_q;
    head_d   = head_q;
    tail_d   = tail_q;
    lr_d     = lr_q;
    cur_d    = cur_q;
    goal_d   = goal_q;
    done_d   = done_q;
    count_d  = count_q;
    open_d   = open_q;
    unrep_d  = unrep_q;
    mem_we_o = 1'b0;
    meta_o.entry_valid = 1'b0;
    meta_o.from_store  = 1'b0;
    if (cfg_we_i) begin
      s_d     = s_new;
      head_d  = '0;
      tail_d  = '0;
      lr_d    = IDX_W'(s_new - CNT_W'(1));
      cur_d   = '0;
      goal_d  = '0;
      done_d  = '0;
      count_d = '0;
      open_d  = 1'b0;
      unrep_d = 1'b0;
    end else if (fire_i) begin
      case (op_i)
        OP_APPEND: begin
          mem_we_o = 1'b1;
          head_d   = inc_slot(head_q, s_q);
          if (full) begin
            tail_d = inc_slot(tail_q, s_q);
          end else begin
            count_d = count_q + IDX_W'(1);
          end
          open_d = 1'b0;
          meta_o.entry_valid = 1'b1;
        end
        OP_START_NEWEST: begin
          unrep_d = 1'b0;
          goal_d  = lim_all ? count_q : IDX_W'(read_limit_i);
          done_d  = '0;
          cur_d   = dec_slot(head_q, s_q);
          open_d  = 1'b1;
        end
        OP_START_UNREP: begin
          unrep_d = 1'b1;
          goal_d  = unrep_goal;
          done_d  = '0;
          cur_d   = inc_slot(lr_q, s_q);
          open_d  = 1'b1;
        end
        OP_NEXT: begin
          if (can_read) begin
            meta_o.entry_valid = 1'b1;
            meta_o.from_store  = 1'b1;
            done_d = done_q + IDX_W'(1);
            if (unrep_q) begin
              lr_d  = cur_q;
              cur_d = inc_slot(cur_q, s_q);
            end else begin
              cur_d = dec_slot(cur_q, s_q);
            end
          end
        end
        default: begin
        end
      endcase
    end
    meta_o.stored_count = COUNT_W'(count_d);
  end

  assign mem_waddr_o = head_q;
  assign mem_raddr_o = cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q     <= S_RESET;
      head_q  <= '0;
      tail_q  <= '0;
      lr_q    <= IDX_W'(S_RESET - CNT_W'(1));
      cur_q   <= '0;
      goal_q  <= '0;
      done_q  <= '0;
      count_q <= '0;
      open_q  <= 1'b0;
      unrep_q <= 1'b0;
    end else begin
      s_q     <= s_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      lr_q    <= lr_d;
      cur_q   <= cur_d;
      goal_q  <= goal_d;
      done_q  <= done_d;
      count_q <= count_d;
      open_q  <= open_d;
      unrep_q <= unrep_d;
    end
  end

  // fill count as seen from the ring pointers
  always_comb begin
    if (head_q >= tail_q) begin
      stored_chk = head_q - tail_q;
    end else begin
      stored_chk = IDX_W'(XW'(s_q) - XW'(tail_q - head_q));
    end
  end

  a_count_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_chk == count_q)
    else $error("fill count out of step with head and tail");

  a_ptrs_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (XW'(head_q) < XW'(s_q)) && (XW'(tail_q) < XW'(s_q)) &&
    (XW'(lr_q) < XW'(s_q)) && (XW'(cur_q) < XW'(s_q)))
    else $error("ring pointer beyond slot count");

  a_done_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (done_q <= goal_q))
    else $error("cursor read past its goal");

  a_append_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (op_i == OP_APPEND)) |=> !open_q)
    else $error("cursor still open after append");

endmodule

// ===== sv/circular_event_log_unit.sv =====
// ----------------------------------------------------------------------------
// circular_event_log_unit
// ring-buffer event log with newest-first and unreported read cursors
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the output is not stalled, and
// returns exactly one result per request. A request passes the input
// register, then the pointer update and memory read, whose read data lands
// in the result register. Each request writes at most one slot and reads one
// slot of the single-port-write, single-port-read entry memory, which sets
// the rate at one request per cycle. Stored entries need no clearing after
// reset; reads only ever reach slots written since the last pointer reset.
// Writing slots_in_use resets head, tail and cursor and must happen while idle.
// ----------------------------------------------------------------------------
module circular_event_log_unit import cel_pkg::*; #(
  parameter int unsigned MAX_SLOTS    = DEF_MAX_SLOTS,
  parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // entry_time, entry_type, entry_payload, read_limit, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // operation
  input  logic [OP_W-1:0]       s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // out_time, out_type, out_payload, stored_count, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // entry_valid
  output logic                  m_axis_tuser_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SLOTS);

  logic               in_valid_q;
  op_e                op_q;
  logic [TIME_W-1:0]    time_q;
  logic [TYPE_W-1:0]    type_q;
  logic [PAYLOAD_W-1:0] payload_q;
  logic [LIMIT_W-1:0]   limit_q;

  logic               res_valid_q;
  res_meta_t          meta_q, meta;
  logic [TIME_W-1:0]    app_time_q;
  logic [TYPE_W-1:0]    app_type_q;
  logic [PAYLOAD_W-1:0] app_payload_q;

  logic                    adv, s_acc, fire, is_append;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr;
  logic [TIME_W-1:0]       rd_time;
  logic [TYPE_W-1:0]       rd_type;
  logic [PAYLOAD_BITS-1:0] rd_payload;

  logic [TIME_W-1:0]    out_time;
  logic [TYPE_W-1:0]    out_type;
  logic [PAYLOAD_W-1:0] out_payload;

  assign adv             = !res_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign fire            = in_valid_q && adv;
  assign is_append       = (op_q == OP_APPEND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q      <= op_e'(s_axis_tuser_i);
      time_q    <= s_axis_tdata_i[0 +: TIME_W];
      type_q    <= s_axis_tdata_i[IN_TYPE_LSB +: TYPE_W];
      payload_q <= s_axis_tdata_i[IN_PAYLOAD_LSB +: PAYLOAD_W];
      limit_q   <= s_axis_tdata_i[IN_LIMIT_LSB +: LIMIT_W];
    end
    if (fire) begin
      meta_q        <= meta;
      app_time_q    <= is_append ? time_q : '0;
      app_type_q    <= is_append ? type_q : '0;
      app_payload_q <= is_append ? PAYLOAD_W'(PAYLOAD_BITS'(payload_q)) : '0;
    end
  end

  cel_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fire_i       (fire),
    .op_i         (op_q),
    .read_limit_i (limit_q),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_raddr_o  (mem_raddr),
    .meta_o       (meta)
  );

  cel_store #(
    .MAX_SLOTS    (MAX_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .we_i       (mem_we),
    .waddr_i    (mem_waddr),
    .wtime_i    (time_q),
    .wtype_i    (type_q),
    .wpayload_i (PAYLOAD_BITS'(payload_q)),
    .re_i       (fire),
    .raddr_i    (mem_raddr),
    .rtime_o    (rd_time),
    .rtype_o    (rd_type),
    .rpayload_o (rd_payload)
  );

  assign out_time    = meta_q.from_store ? rd_time : app_time_q;
  assign out_type    = meta_q.from_store ? rd_type : app_type_q;
  assign out_payload = meta_q.from_store ? PAYLOAD_W'(rd_payload) : app_payload_q;

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tuser_o  = meta_q.entry_valid;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, meta_q.stored_count, out_payload,
                            out_type, out_time};

endmodule

// ===== sim/circular_event_log_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_event_log_unit_checker
// watches both streams and the register port of the event log, keeps its own
// ring model, predicts one result per request and compares it field by field
// ----------------------------------------------------------------------------
module circular_event_log_unit_checker import cel_pkg::*; #(
  parameter int unsigned MAX_SLOTS    = DEF_MAX_SLOTS,
  parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [OP_W-1:0]       s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic                  m_axis_tuser_i,
  output int                    err_cnt_o,
  output int                    pending_o,
  output int                    entries_read_o
);

  localparam int unsigned IDX_W         = 10;
  localparam int unsigned OUT_TYPE_LSB  = TIME_W;
  localparam int unsigned OUT_PL_LSB    = TIME_W + TYPE_W;
  localparam int unsigned OUT_COUNT_LSB = TIME_W + TYPE_W + PAYLOAD_W;
  localparam logic [63:0] PL_MASK = (PAYLOAD_BITS >= 64) ? '1 :
                                    ((64'd1 << PAYLOAD_BITS) - 64'd1);

  typedef struct packed {
    logic                 entry_valid;
    logic [TIME_W-1:0]    ts;
    logic [TYPE_W-1:0]    kind;
    logic [PAYLOAD_W-1:0] payload;
    logic [COUNT_W-1:0]   count;
  } log_result_t;

  logic [CFG_W-1:0] slots_cfg;
  logic [IDX_W-1:0] head, tail, last_rep, cur_slot, cur_goal, cur_done;
  logic             cur_open, cur_unrep;
  logic [TIME_W-1:0] ts_mem [MAX_SLOTS];
  logic [TYPE_W-1:0] kind_mem [MAX_SLOTS];
  logic [63:0]       payload_mem [MAX_SLOTS];
  log_result_t       log_results_q [$];
  int                errs;
  int                reads;

  function automatic int ring_size();
    int s;
    s = int'(slots_cfg);
    if (s < 2) s = 2;
    if (s > int'(MAX_SLOTS)) s = MAX_SLOTS;
    return s;
  endfunction

  function automatic int wrap_inc(input int i, input int s);
    return (i + 1 >= s) ? 0 : i + 1;
  endfunction

  function automatic int wrap_dec(input int i, input int s);
    return (i == 0) ? s - 1 : i - 1;
  endfunction

  function automatic int fill_level(input int s);
    if (head == tail) return 0;
    if (head > tail) return int'(head) - int'(tail);
    return s - (int'(tail) - int'(head));
  endfunction

  task automatic reset_pointers();
    head      = '0;
    tail      = '0;
    last_rep  = IDX_W'(ring_size() - 1);
    cur_open  = 1'b0;
    cur_unrep = 1'b0;
    cur_slot  = '0;
    cur_goal  = '0;
    cur_done  = '0;
  endtask

  function automatic log_result_t log_step(input op_e op,
                                           input logic [TIME_W-1:0] ts,
                                           input logic [TYPE_W-1:0] kind,
                                           input logic [PAYLOAD_W-1:0] payload,
                                           input logic [LIMIT_W-1:0] limit);
    log_result_t r;
    int s, n;
    s = ring_size();
    r = '0;
    case (op)
      OP_APPEND: begin
        ts_mem[head]      = ts;
        kind_mem[head]    = kind;
        payload_mem[head] = 64'(payload) & PL_MASK;
        r.entry_valid = 1'b1;
        r.ts          = ts;
        r.kind        = kind;
        r.payload     = PAYLOAD_W'(64'(payload) & PL_MASK);
        head = IDX_W'(wrap_inc(head, s));
        if (head == tail) tail = IDX_W'(wrap_inc(tail, s));
        ts_mem[head]      = '0;
        kind_mem[head]    = '0;
        payload_mem[head] = '0;
        cur_open = 1'b0;
      end
      OP_START_NEWEST: begin
        n = fill_level(s);
        cur_unrep = 1'b0;
        cur_goal  = IDX_W'((limit == 0 || int'(limit) > n) ? n : int'(limit));
        cur_done  = '0;
        cur_slot  = IDX_W'(wrap_dec(head, s));
        cur_open  = 1'b1;
      end
      OP_START_UNREP: begin
        cur_unrep = 1'b1;
        if (head > last_rep) cur_goal = IDX_W'(int'(head) - int'(last_rep) - 1);
        else cur_goal = IDX_W'(s - (int'(last_rep) - int'(head)) - 1);
        cur_done = '0;
        cur_slot = IDX_W'(wrap_inc(last_rep, s));
        cur_open = 1'b1;
      end
      default: begin
        if (cur_open && cur_done < cur_goal) begin
          r.entry_valid = 1'b1;
          r.ts          = ts_mem[cur_slot];
          r.kind        = kind_mem[cur_slot];
          r.payload     = PAYLOAD_W'(payload_mem[cur_slot]);
          cur_done = cur_done + 1'b1;
          reads++;
          if (cur_unrep) begin
            last_rep = cur_slot;
            cur_slot = IDX_W'(wrap_inc(cur_slot, s));
          end else begin
            cur_slot = IDX_W'(wrap_dec(cur_slot, s));
          end
        end
      end
    endcase
    r.count = COUNT_W'(fill_level(s));
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    log_result_t want, got;
    if (!rst_ni) begin
      slots_cfg = CFG_W'(CFG_RESET);
      for (int i = 0; i < int'(MAX_SLOTS); i++) begin
        ts_mem[i]      = '0;
        kind_mem[i]    = '0;
        payload_mem[i] = '0;
      end
      reset_pointers();
      log_results_q.delete();
      errs = 0;
      reads = 0;
      err_cnt_o      <= 0;
      pending_o      <= 0;
      entries_read_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.entry_valid = m_axis_tuser_i;
        got.ts          = m_axis_tdata_i[0 +: TIME_W];
        got.kind        = m_axis_tdata_i[OUT_TYPE_LSB +: TYPE_W];
        got.payload     = m_axis_tdata_i[OUT_PL_LSB +: PAYLOAD_W];
        got.count       = m_axis_tdata_i[OUT_COUNT_LSB +: COUNT_W];
        if (log_results_q.size() == 0) begin
          $error("result with no request pending: tuser %0b tdata 0x%0h",
                 m_axis_tuser_i, m_axis_tdata_i);
          errs++;
        end else begin
          want = log_results_q.pop_front();
          check_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
          check_field("out_time", want.ts, got.ts);
          check_field("out_type", 32'(want.kind), 32'(got.kind));
          check_field("out_payload", want.payload, got.payload);
          check_field("stored_count", 32'(want.count), 32'(got.count));
        end
      end
      if (cfg_we_i) begin
        slots_cfg = cfg_wdata_i;
        reset_pointers();
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        log_results_q.push_back(log_step(op_e'(s_axis_tuser_i),
                                         s_axis_tdata_i[0 +: TIME_W],
                                         s_axis_tdata_i[IN_TYPE_LSB +: TYPE_W],
                                         s_axis_tdata_i[IN_PAYLOAD_LSB +: PAYLOAD_W],
                                         s_axis_tdata_i[IN_LIMIT_LSB +: LIMIT_W]));
      end
      err_cnt_o      <= errs;
      pending_o      <= log_results_q.size();
      entries_read_o <= reads;
    end
  end

endmodule

// ===== sim/tb_circular_event_log_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_event_log_unit
// drives directed and random request streams with stalls on both sides,
// rewrites the slot count between phases and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_circular_event_log_unit;
  import cel_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [OP_W-1:0]       s_axis_tuser_i = OP_APPEND;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  int err_cnt, pending, entries_read;
  int send_idle = 36;
  int recv_idle = 80;
  int items_sent = 0;
  int op_cnt [4] = '{0, 0, 0, 0};
  int cfg_writes = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  circular_event_log_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  circular_event_log_unit_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending),
    .entries_read_o  (entries_read)
  );

  always @(posedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= recv_idle);

  task automatic send_request(input op_e op, input logic [TIME_W-1:0] ts,
                              input logic [TYPE_W-1:0] kind,
                              input logic [PAYLOAD_W-1:0] payload,
                              input logic [LIMIT_W-1:0] limit);
    logic [IN_DATA_W-1:0] req;
    req = '0;
    req[0 +: TIME_W]              = ts;
    req[IN_TYPE_LSB +: TYPE_W]    = kind;
    req[IN_PAYLOAD_LSB +: PAYLOAD_W] = payload;
    req[IN_LIMIT_LSB +: LIMIT_W]  = limit;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= req;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    op_cnt[op]++;
  endtask

  task automatic send_op(input op_e op, input logic [LIMIT_W-1:0] limit);
    send_request(op, $urandom, TYPE_W'($urandom_range(255)), $urandom, limit);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_slots(input logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [LIMIT_W-1:0] rand_limit();
    return ($urandom_range(3) == 0) ? LIMIT_W'($urandom_range(1023))
                                    : LIMIT_W'($urandom_range(6));
  endfunction

  task automatic run_traffic(input int target, input int ring);
    int start, pick, k;
    start = items_sent;
    while (items_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // append bursts, now and then long enough to wrap the ring
        k = ($urandom_range(7) == 0) ? $urandom_range(ring, 2 * ring + 2)
                                     : $urandom_range(1, 6);
        repeat (k) send_op(OP_APPEND, rand_limit());
      end else if (pick < 55) begin
        send_op(OP_START_NEWEST, rand_limit());
        repeat ($urandom_range(1, 10)) send_op(OP_NEXT, rand_limit());
      end else if (pick < 80) begin
        send_op(OP_START_UNREP, rand_limit());
        repeat ($urandom_range(1, 10)) send_op(OP_NEXT, rand_limit());
      end else begin
        send_op(op_e'($urandom_range(3)), rand_limit());
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] slot_settings [10];
    int ring;
    slot_settings = '{11'd3, 11'd2, 11'd0, 11'd1, 11'd64,
                      11'd2047, 11'd7, 11'd65, 11'd1024, 11'd33};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // closed cursor and empty log
    send_op(OP_NEXT, '0);
    send_op(OP_START_NEWEST, '0);
    send_op(OP_NEXT, '0);
    send_op(OP_START_UNREP, '1);
    send_op(OP_NEXT, '0);
    // field extremes
    send_request(OP_APPEND, '0, '0, '0, '0);
    send_request(OP_APPEND, '1, '1, '1, '1);
    send_op(OP_APPEND, '0);
    // newest-first: all, limit above count, limit of one
    send_op(OP_START_NEWEST, '0);
    repeat (4) send_op(OP_NEXT, '0);
    send_op(OP_START_NEWEST, '1);
    send_op(OP_NEXT, '0);
    send_op(OP_START_NEWEST, LIMIT_W'(1));
    repeat (2) send_op(OP_NEXT, '0);
    // unreported read, append closes the cursor, then resume
    send_op(OP_START_UNREP, '0);
    repeat (2) send_op(OP_NEXT, '0);
    send_op(OP_APPEND, '0);
    send_op(OP_NEXT, '0);
    send_op(OP_START_UNREP, '0);
    repeat (3) send_op(OP_NEXT, '0);
    drain();

    for (int p = 0; p < 10; p++) begin
      if (p < 4) begin
        send_idle = 36;
        recv_idle = 80;
      end else if (p < 7) begin
        send_idle = 80;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_slots(slot_settings[p]);
      ring = (slot_settings[p] < 2) ? 2 :
             (slot_settings[p] > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : slot_settings[p];
      run_traffic(48, ring);
      drain();
    end

    $display("covered %0d requests: %0d appends, %0d newest-first, %0d unreported, %0d next",
             items_sent, op_cnt[OP_APPEND], op_cnt[OP_START_NEWEST],
             op_cnt[OP_START_UNREP], op_cnt[OP_NEXT]);
    $display("%0d slot-count writes, %0d entries read back, %0d mismatches",
             cfg_writes, entries_read, err_cnt);
    if (err_cnt == 0) begin
      $display("** circular_event_log_unit: PASSED **");
    end else begin
      $display("** circular_event_log_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("** circular_event_log_unit: FAILED **");
    $finish;
  end

endmodule
